// ----- hw/rtl/bsc_pkg.sv -----
// Shared types, constants and calibration unpacking for the barometer
// sample compensation block. No dependencies.
package bsc_pkg;

	localparam int RAW_W = 24;
	localparam int PRES_W = 26;
	localparam int TEMP_W = 16;
	localparam int CAL_W = 48;
	localparam int OSR_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_FRAC_DEF = 8;

	localparam int DEN_W = 8;
	localparam int DIV_W = 36;
	localparam int DIV_BPS = 4;
	localparam int DIV_STAGES = DIV_W / DIV_BPS;
	localparam int SHIFT_SMALL = 5;
	localparam int SHIFT_BIG = 11;
	localparam int SC_W = 31;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [DEN_W-1:0] SCALE_DEN [8] = '{
		8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_LOW,
		CFG_CAL_MID,
		CFG_CAL_HIGH,
		CFG_P_OSR,
		CFG_T_OSR
	} cfg_idx_t;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

	typedef struct packed {
		logic signed [SC_W-1:0] psc;
		logic signed [SC_W-1:0] tsc;
	} scaled_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic coef_t unpack_calib(input logic [CAL_W-1:0] lo,
		input logic [CAL_W-1:0] mid, input logic [CAL_W-1:0] hi);
		logic [3*CAL_W-1:0] b;
		coef_t c;
		b = {lo, mid, hi};
		c.c0 = b[143:132];
		c.c1 = b[131:120];
		c.c00 = b[119:100];
		c.c10 = b[99:80];
		c.c01 = b[79:64];
		c.c11 = b[63:48];
		c.c20 = b[47:32];
		c.c21 = b[31:16];
		c.c30 = b[15:0];
		return c;
	endfunction

endpackage

// ----- hw/rtl/bsc_div.sv -----
// Pipelined restoring divider by a small divisor, DIV_BPS quotient bits per stage.
// Depends on bsc_pkg.
module bsc_div import bsc_pkg::*; (
	input  logic             clk,
	input  logic [DIV_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic             neg,
	output logic [DIV_W-1:0] quo,
	output logic             neg_out
);

	logic [DIV_W-1:0] nq_s [DIV_STAGES];
	logic [DEN_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic             neg_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
		logic [DIV_W-1:0] nq_i;
		logic [DIV_W-1:0] nq_n;
		logic [DEN_W-1:0] rem_i;
		logic [DEN_W-1:0] rem_n;
		logic [DEN_W-1:0] den_i;
		logic             neg_i;
		logic [DEN_W:0]   tr;

		if (g == 0) begin : g_first
			assign nq_i = num;
			assign rem_i = '0;
			assign den_i = den;
			assign neg_i = neg;
		end else begin : g_next
			assign nq_i = nq_s[g-1];
			assign rem_i = rem_s[g-1];
			assign den_i = den_s[g-1];
			assign neg_i = neg_s[g-1];
		end

		always_comb begin
			nq_n = nq_i;
			rem_n = rem_i;
			tr = '0;
			for (int j = 0; j < DIV_BPS; j++) begin
				tr = {rem_n, nq_n[DIV_W-1]};
				nq_n = {nq_n[DIV_W-2:0], 1'b0};
				if (tr >= {1'b0, den_i}) begin
					tr = tr - {1'b0, den_i};
					nq_n[0] = 1'b1;
				end
				rem_n = tr[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			nq_s[g] <= nq_n;
			rem_s[g] <= rem_n;
			den_s[g] <= den_i;
			neg_s[g] <= neg_i;
		end
	end

	assign quo = nq_s[DIV_STAGES-1];
	assign neg_out = neg_s[DIV_STAGES-1];

endmodule

// ----- hw/rtl/bsc_front.sv -----
// Front end: takes sample pairs, picks scale divisors and scales both samples to Q24.
// Depends on bsc_pkg and bsc_div.
module bsc_front import bsc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic signed [RAW_W-1:0] raw_p,
	input  logic signed [RAW_W-1:0] raw_t,
	input  logic [OSR_W-1:0]        p_osr,
	input  logic [OSR_W-1:0]        t_osr,
	output logic                    push,
	output scaled_t                 item
);

	logic [RAW_W-1:0] mag_p;
	logic [RAW_W-1:0] mag_t;
	logic [DIV_W-1:0] num_p;
	logic [DIV_W-1:0] num_t;

	logic             v_s0;
	logic [DIV_W-1:0] num_p_s0;
	logic [DIV_W-1:0] num_t_s0;
	logic [DEN_W-1:0] den_p_s0;
	logic [DEN_W-1:0] den_t_s0;
	logic             neg_p_s0;
	logic             neg_t_s0;

	logic             vld_q [DIV_STAGES];
	logic [DIV_W-1:0] quo_p;
	logic [DIV_W-1:0] quo_t;
	logic             neg_p;
	logic             neg_t;
	logic             push_q;
	scaled_t          item_q;

	always_comb begin
		mag_p = raw_p[RAW_W-1] ? RAW_W'(-raw_p) : RAW_W'(raw_p);
		mag_t = raw_t[RAW_W-1] ? RAW_W'(-raw_t) : RAW_W'(raw_t);
		num_p = DIV_W'(mag_p) << (p_osr[OSR_W-1] ? SHIFT_BIG : SHIFT_SMALL);
		num_t = DIV_W'(mag_t) << (t_osr[OSR_W-1] ? SHIFT_BIG : SHIFT_SMALL);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			num_p_s0 <= num_p;
			num_t_s0 <= num_t;
			den_p_s0 <= SCALE_DEN[p_osr];
			den_t_s0 <= SCALE_DEN[t_osr];
			neg_p_s0 <= raw_p[RAW_W-1];
			neg_t_s0 <= raw_t[RAW_W-1];
		end
	end

	bsc_div u_div_p (
		.clk     (clk),
		.num     (num_p_s0),
		.den     (den_p_s0),
		.neg     (neg_p_s0),
		.quo     (quo_p),
		.neg_out (neg_p)
	);

	bsc_div u_div_t (
		.clk     (clk),
		.num     (num_t_s0),
		.den     (den_t_s0),
		.neg     (neg_t_s0),
		.quo     (quo_t),
		.neg_out (neg_t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			for (int i = 0; i < DIV_STAGES; i++) vld_q[i] <= 1'b0;
			push_q <= 1'b0;
		end else begin
			v_s0 <= accept;
			vld_q[0] <= v_s0;
			for (int i = 1; i < DIV_STAGES; i++) vld_q[i] <= vld_q[i-1];
			push_q <= vld_q[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		item_q.psc <= neg_p ? -$signed(quo_p[SC_W-1:0]) : $signed(quo_p[SC_W-1:0]);
		item_q.tsc <= neg_t ? -$signed(quo_t[SC_W-1:0]) : $signed(quo_t[SC_W-1:0]);
	end

	assign push = push_q;
	assign item = item_q;

endmodule

// ----- hw/rtl/bsc_queue.sv -----
// Short queue of scaled sample pairs between the front and back ends.
// Depends on bsc_pkg.
module bsc_queue import bsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  scaled_t wdata,
	input  logic    pop,
	output scaled_t rdata,
	output q_stat_t stat
);

	scaled_t         ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_pop = pop && !stat.empty;
	assign do_push = push && (!stat.full || do_pop);
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
		end
	end

endmodule

// ----- hw/rtl/bsc_back.sv -----
// Back end: evaluates the pressure and temperature polynomials in Q24 and
// converts to the output format. Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_vld,
	input  scaled_t                  in,
	input  coef_t                    cf,
	output logic                     done,
	output logic signed [PRES_W-1:0] pres,
	output logic signed [TEMP_W-1:0] temp,
	output logic                     sat
);

	localparam int SH = 24 - OUT_FRAC_BITS;
	localparam logic signed [63:0] PBIAS = (64'sd1 <<< SH) - 64'sd1;
	localparam logic signed [43:0] TBIAS = (44'sd1 <<< SH) - 44'sd1;
	localparam logic signed [63:0] PMAX = (64'sd1 <<< (PRES_W-1)) - 64'sd1;
	localparam logic signed [63:0] PMIN = -(64'sd1 <<< (PRES_W-1));
	localparam logic signed [43:0] TMAX = (44'sd1 <<< (TEMP_W-1)) - 44'sd1;
	localparam logic signed [43:0] TMIN = -(44'sd1 <<< (TEMP_W-1));

	function automatic logic signed [71:0] trunc_q24(input logic signed [95:0] x);
		logic signed [95:0] b;
		b = x + (x[95] ? 96'sd16777215 : 96'sd0);
		return b[95:24];
	endfunction

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic signed [SC_W-1:0] psc_s1, psc_s2, psc_s3, psc_s4, psc_s5;
	logic signed [46:0]     m30_s1, m21_s1, m01_s1, m01_s2, m01_s3, m01_s4, m01_s5;
	logic signed [61:0]     mtp_s1;
	logic signed [42:0]     m1_s1;
	logic signed [47:0]     inner_s2, rr_s2;
	logic signed [37:0]     tp_s2;
	logic signed [43:0]     t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic signed [55:0]     pa_lo_s3;
	logic signed [54:0]     pa_hi_s3;
	logic signed [62:0]     pb_lo_s3;
	logic signed [61:0]     pb_hi_s3;
	logic signed [78:0]     pa_s4;
	logic signed [85:0]     pb_s4;
	logic signed [55:0]     qua2_s5;
	logic signed [61:0]     qua3_s5;
	logic signed [59:0]     pc_lo_s6;
	logic signed [58:0]     pc_hi_s6;
	logic signed [63:0]     acc_s6, acc_s7, acc_s8;
	logic signed [86:0]     pc_s7;
	logic signed [62:0]     q_s8;
	logic signed [63:0]     p_s9;
	logic signed [PRES_W-1:0] pres_s10;
	logic signed [TEMP_W-1:0] temp_s10;
	logic                   sat_s10;

	logic signed [71:0]     tr_mtp, tr_pa, tr_pb, tr_pc;
	logic signed [63:0]     pr;
	logic signed [43:0]     trr;

	always_comb begin
		tr_mtp = trunc_q24(96'(mtp_s1));
		tr_pa = trunc_q24(96'(pa_s4));
		tr_pb = trunc_q24(96'(pb_s4));
		tr_pc = trunc_q24(96'(pc_s7));
		pr = (p_s9 + (p_s9[63] ? PBIAS : 64'sd0)) >>> SH;
		trr = (t_s9 + (t_s9[43] ? TBIAS : 44'sd0)) >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
		end else begin
			v_s1 <= in_vld; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		// products of the scaled samples
		psc_s1 <= in.psc;
		m30_s1 <= $signed(cf.c30) * $signed(in.psc);
		m21_s1 <= $signed(cf.c21) * $signed(in.psc);
		m01_s1 <= $signed(cf.c01) * $signed(in.tsc);
		mtp_s1 <= $signed(in.tsc) * $signed(in.psc);
		m1_s1 <= $signed(cf.c1) * $signed(in.tsc);

		psc_s2 <= psc_s1;
		m01_s2 <= m01_s1;
		inner_s2 <= $signed({cf.c20, 24'd0}) + m30_s1;
		rr_s2 <= $signed({cf.c11, 24'd0}) + m21_s1;
		tp_s2 <= tr_mtp[37:0];
		t_s2 <= $signed({cf.c0, 23'd0}) + m1_s1;

		psc_s3 <= psc_s2;
		m01_s3 <= m01_s2;
		t_s3 <= t_s2;
		pa_lo_s3 <= psc_s2 * $signed({1'b0, inner_s2[23:0]});
		pa_hi_s3 <= psc_s2 * $signed(inner_s2[47:24]);
		pb_lo_s3 <= tp_s2 * $signed({1'b0, rr_s2[23:0]});
		pb_hi_s3 <= tp_s2 * $signed(rr_s2[47:24]);

		psc_s4 <= psc_s3;
		m01_s4 <= m01_s3;
		t_s4 <= t_s3;
		pa_s4 <= $signed({pa_hi_s3, 24'd0}) + pa_lo_s3;
		pb_s4 <= $signed({pb_hi_s3, 24'd0}) + pb_lo_s3;

		psc_s5 <= psc_s4;
		m01_s5 <= m01_s4;
		t_s5 <= t_s4;
		qua2_s5 <= $signed({cf.c10, 24'd0}) + $signed(tr_pa[54:0]);
		qua3_s5 <= tr_pb[61:0];

		t_s6 <= t_s5;
		pc_lo_s6 <= psc_s5 * $signed({1'b0, qua2_s5[27:0]});
		pc_hi_s6 <= psc_s5 * $signed(qua2_s5[55:28]);
		acc_s6 <= qua3_s5 + m01_s5;

		t_s7 <= t_s6;
		acc_s7 <= acc_s6;
		pc_s7 <= $signed({pc_hi_s6, 28'd0}) + pc_lo_s6;

		t_s8 <= t_s7;
		acc_s8 <= acc_s7;
		q_s8 <= tr_pc[62:0];

		t_s9 <= t_s8;
		p_s9 <= $signed({cf.c00, 24'd0}) + q_s8 + acc_s8;

		// scale to the output format and clamp
		if (pr > PMAX) pres_s10 <= PMAX[PRES_W-1:0];
		else if (pr < PMIN) pres_s10 <= PMIN[PRES_W-1:0];
		else pres_s10 <= pr[PRES_W-1:0];
		if (trr > TMAX) temp_s10 <= TMAX[TEMP_W-1:0];
		else if (trr < TMIN) temp_s10 <= TMIN[TEMP_W-1:0];
		else temp_s10 <= trr[TEMP_W-1:0];
		sat_s10 <= (pr > PMAX) || (pr < PMIN) || (trr > TMAX) || (trr < TMIN);
	end

	assign done = v_s10;
	assign pres = pres_s10;
	assign temp = temp_s10;
	assign sat = sat_s10;

endmodule

// ----- hw/rtl/barometer_sample_compensation.sv -----
// Top level of the barometer sample compensation block: configuration registers,
// front end, queue and back end. Depends on bsc_pkg, bsc_front, bsc_queue, bsc_back.
//
//   channel | signals                                     | transfer
//   --------+---------------------------------------------+-------------------------
//   sample  | start, busy, raw_pressure, raw_temperature  | start && !busy
//   result  | done, pressure_q8, temperature_q8, saturated| done (one cycle)
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | cfg_valid && cfg_ready
//
// One sample pair per cycle, back to back, while busy is low. From the accepting
// edge to the result the path runs through 1 input stage, 9 divider stages (4 quotient
// bits each), 1 push stage, 1 queue stage and 10 polynomial stages.
// Reset clears control state and the configuration registers; the result side
// cannot stall, the back end drains the queue every cycle.
module barometer_sample_compensation import bsc_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [RAW_W-1:0]  raw_pressure,
	input  logic signed [RAW_W-1:0]  raw_temperature,
	output logic                     done,
	output logic signed [PRES_W-1:0] pressure_q8,
	output logic signed [TEMP_W-1:0] temperature_q8,
	output logic                     saturated,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CAL_W-1:0]         cfg_data
);

	logic [CAL_W-1:0] cal_low_q;
	logic [CAL_W-1:0] cal_mid_q;
	logic [CAL_W-1:0] cal_high_q;
	logic [OSR_W-1:0] p_osr_q;
	logic [OSR_W-1:0] t_osr_q;
	coef_t            coef;
	logic             accept;
	logic             fe_push;
	scaled_t          fe_item;
	scaled_t          q_head;
	q_stat_t          q_stat;
	logic             be_pop;

	assign cfg_ready = 1'b1;
	assign coef = unpack_calib(cal_low_q, cal_mid_q, cal_high_q);
	assign busy = q_stat.full;
	assign accept = start && !busy;
	assign be_pop = !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_low_q <= '0;
			cal_mid_q <= '0;
			cal_high_q <= '0;
			p_osr_q <= '0;
			t_osr_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAL_LOW: cal_low_q <= cfg_data;
				CFG_CAL_MID: cal_mid_q <= cfg_data;
				CFG_CAL_HIGH: cal_high_q <= cfg_data;
				CFG_P_OSR: p_osr_q <= cfg_data[OSR_W-1:0];
				CFG_T_OSR: t_osr_q <= cfg_data[OSR_W-1:0];
				default: ;
			endcase
		end
	end

	bsc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.raw_p  (raw_pressure),
		.raw_t  (raw_temperature),
		.p_osr  (p_osr_q),
		.t_osr  (t_osr_q),
		.push   (fe_push),
		.item   (fe_item)
	);

	bsc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fe_push),
		.wdata  (fe_item),
		.pop    (be_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	bsc_back #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (be_pop),
		.in     (q_head),
		.cf     (coef),
		.done   (done),
		.pres   (pressure_q8),
		.temp   (temperature_q8),
		.sat    (saturated)
	);

`ifndef ASSERT_OFF
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(fe_push && q_stat.full))
		else $error("front pushed into a full queue");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |->
		(pressure_q8 == {1'b0, {(PRES_W-1){1'b1}}}) ||
		(pressure_q8 == {1'b1, {(PRES_W-1){1'b0}}}) ||
		(temperature_q8 == {1'b0, {(TEMP_W-1){1'b1}}}) ||
		(temperature_q8 == {1'b1, {(TEMP_W-1){1'b0}}}))
		else $error("saturated flag without a clamped result");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(fe_push) && !$past(q_stat.full) |-> !q_stat.empty)
		else $error("pushed item missing from queue");
`endif

endmodule

// ----- verif/bsc_result_checker.sv -----
// Result checker for the barometer sample compensation block: tracks the
// configuration channel, computes the compensated outputs of each sample
// transfer and compares them with the result strobes. Depends on bsc_pkg.
module bsc_result_checker import bsc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic signed [RAW_W-1:0]  raw_pressure,
	input  logic signed [RAW_W-1:0]  raw_temperature,
	input  logic                     done,
	input  logic signed [PRES_W-1:0] pressure_q8,
	input  logic signed [TEMP_W-1:0] temperature_q8,
	input  logic                     saturated,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CAL_W-1:0]         cfg_data,
	output int                       errors,
	output int                       pending,
	output int                       checked,
	output int                       clamped
);

	localparam longint Q_ONE = 64'sd16777216;
	localparam longint Q_LIM = 64'sh3FFFFFFFFFFFFFFF;

	typedef struct {
		logic signed [PRES_W-1:0] pres;
		logic signed [TEMP_W-1:0] temp;
		logic                     sat;
	} comp_t;

	logic [CAL_W-1:0] cal_lo, cal_mid, cal_hi;
	logic [OSR_W-1:0] p_osr, t_osr;
	comp_t            comp_q[$];

	function automatic longint osr_divisor(input logic [OSR_W-1:0] code);
		longint tab[8] = '{524288, 1572864, 3670016, 7864320,
			253952, 516096, 1040384, 2088960};
		return tab[code];
	endfunction

	function automatic longint lim(input longint v);
		if (v > Q_LIM)
			return Q_LIM;
		if (v < -Q_LIM)
			return -Q_LIM;
		return v;
	endfunction

	function automatic longint qadd(input longint a, input longint b);
		return lim(lim(a) + lim(b));
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		logic signed [127:0] pr;
		pr = 128'(a) * 128'(b);
		pr = pr / 128'sd16777216;
		if (pr > 128'(Q_LIM))
			return Q_LIM;
		if (pr < -128'(Q_LIM))
			return -Q_LIM;
		return longint'(pr);
	endfunction

	function automatic comp_t compensate(input logic signed [RAW_W-1:0] rp,
		input logic signed [RAW_W-1:0] rt);
		logic [143:0] b;
		longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
		longint psc, tsc, t, p, inner, qua2, qua3, po, tout;
		comp_t r;
		b = {cal_lo, cal_mid, cal_hi};
		c0 = longint'($signed(b[143:132]));
		c1 = longint'($signed(b[131:120]));
		c00 = longint'($signed(b[119:100]));
		c10 = longint'($signed(b[99:80]));
		c01 = longint'($signed(b[79:64]));
		c11 = longint'($signed(b[63:48]));
		c20 = longint'($signed(b[47:32]));
		c21 = longint'($signed(b[31:16]));
		c30 = longint'($signed(b[15:0]));
		psc = (longint'(rp) * Q_ONE) / osr_divisor(p_osr);
		tsc = (longint'(rt) * Q_ONE) / osr_divisor(t_osr);
		t = qadd(c0 * (Q_ONE / 2), c1 * tsc);
		inner = qadd(c20 * Q_ONE, c30 * psc);
		qua2 = qadd(c10 * Q_ONE, qmul(psc, inner));
		qua3 = qmul(qmul(tsc, psc), qadd(c11 * Q_ONE, c21 * psc));
		p = qadd(c00 * Q_ONE, qmul(psc, qua2));
		p = qadd(p, c01 * tsc);
		p = qadd(p, qua3);
		po = p / 64'sd65536;
		tout = t / 64'sd65536;
		r.sat = 1'b0;
		if (po > 33554431) begin
			po = 33554431;
			r.sat = 1'b1;
		end else if (po < -33554432) begin
			po = -33554432;
			r.sat = 1'b1;
		end
		if (tout > 32767) begin
			tout = 32767;
			r.sat = 1'b1;
		end else if (tout < -32768) begin
			tout = -32768;
			r.sat = 1'b1;
		end
		r.pres = po[PRES_W-1:0];
		r.temp = tout[TEMP_W-1:0];
		return r;
	endfunction

	assign pending = comp_q.size();

	always @(posedge clk or negedge arst_n) begin
		comp_t e;
		if (!arst_n) begin
			cal_lo = '0;
			cal_mid = '0;
			cal_hi = '0;
			p_osr = '0;
			t_osr = '0;
			errors = 0;
			checked = 0;
			clamped = 0;
			comp_q.delete();
		end else begin
			if (done) begin
				if (comp_q.size() == 0) begin
					$display("%0t: result with nothing expected: p=%0d t=%0d sat=%0b",
						$time, pressure_q8, temperature_q8, saturated);
					errors++;
				end else begin
					e = comp_q.pop_front();
					checked++;
					if (saturated)
						clamped++;
					if (pressure_q8 !== e.pres) begin
						$display("%0t: pressure_q8 expected %0d actual %0d",
							$time, e.pres, pressure_q8);
						errors++;
					end
					if (temperature_q8 !== e.temp) begin
						$display("%0t: temperature_q8 expected %0d actual %0d",
							$time, e.temp, temperature_q8);
						errors++;
					end
					if (saturated !== e.sat) begin
						$display("%0t: saturated expected %0b actual %0b",
							$time, e.sat, saturated);
						errors++;
					end
				end
			end
			if (start && !busy)
				comp_q.push_back(compensate(raw_pressure, raw_temperature));
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_CAL_LOW: cal_lo = cfg_data;
					CFG_CAL_MID: cal_mid = cfg_data;
					CFG_CAL_HIGH: cal_hi = cfg_data;
					CFG_P_OSR: p_osr = cfg_data[OSR_W-1:0];
					CFG_T_OSR: t_osr = cfg_data[OSR_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- verif/barometer_sample_compensation_test.sv -----
// Testbench top for the barometer sample compensation block: clock, reset,
// configuration phases and bursty sample stimulus. Depends on bsc_pkg,
// barometer_sample_compensation and bsc_result_checker.
module barometer_sample_compensation_test;
	import bsc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 103;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic signed [RAW_W-1:0]  raw_pressure;
	logic signed [RAW_W-1:0]  raw_temperature;
	logic                     done;
	logic signed [PRES_W-1:0] pressure_q8;
	logic signed [TEMP_W-1:0] temperature_q8;
	logic                     saturated;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CAL_W-1:0]         cfg_data;
	int                       errors, pending, checked, clamped;
	int                       cycles;
	int                       sent;

	barometer_sample_compensation u_dut (.*);

	bsc_result_checker u_chk (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("barometer_sample_compensation_test failed");
			$finish;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CAL_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(input logic [CAL_W-1:0] lo, input logic [CAL_W-1:0] mid,
		input logic [CAL_W-1:0] hi, input int posr, input int tosr);
		write_reg(CFG_CAL_LOW, lo);
		write_reg(CFG_CAL_MID, mid);
		write_reg(CFG_CAL_HIGH, hi);
		write_reg(CFG_P_OSR, CAL_W'(posr));
		write_reg(CFG_T_OSR, CAL_W'(tosr));
	endtask

	// hold start across back-to-back transfers; drop it only for a gap
	task automatic send(input logic signed [RAW_W-1:0] p, input logic signed [RAW_W-1:0] t,
		input int gap);
		start = 1'b1;
		raw_pressure = p;
		raw_temperature = t;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent++;
		if (gap > 0) begin
			start = 1'b0;
			raw_pressure = RAW_W'($urandom);
			raw_temperature = RAW_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CAL_W-1:0] pick_cal();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 48'h7FF7FF7FFFF7;
			3: return 48'h800800800008;
			default: return CAL_W'({$urandom, $urandom});
		endcase
	endfunction

	function automatic logic signed [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 7))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			2: return RAW_W'($signed($urandom_range(0, 64)) - 32);
			3: return RAW_W'($urandom_range(0, 4095));
			default: return RAW_W'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [RAW_W-1:0] dp[10];
		int burst, gap;
		dp = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, -24'sd1, 24'sd1,
			24'sh555555, 24'shAAAAAA, 24'sh400000, -24'sh400000, 24'sh00FFFF};
		arst_n = 1'b0;
		start = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		sent = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(24'sh123456, -24'sh0ABCDE, 0);
		send(24'sh7FFFFF, 24'sh800000, 2);
		drain();
		setup('1, '1, '1, 7, 7);
		for (int i = 0; i < 10; i++)
			send(dp[i], dp[9 - i], i % 3);
		drain();
		setup(48'h7FF7FF7FFFF7, 48'hFFFF7FFF7FFF, 48'h7FFF7FFF7FFF, 4, 4);
		for (int i = 0; i < 10; i++)
			send(dp[9 - i], dp[i], 0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			setup(pick_cal(), pick_cal(), pick_cal(), $urandom_range(0, 7),
				$urandom_range(0, 7));
			for (int n = 0; n < PHASE_ITEMS; ) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && n < PHASE_ITEMS; k++, n++) begin
					gap = (k == burst - 1 && ph % 4 != 3) ? $urandom_range(0, 9) : 0;
					send(pick_raw(), pick_raw(), gap);
				end
			end
			drain();
		end

		$display("sent %0d sample pairs over %0d calibration settings", sent, PHASES + 3);
		$display("checked %0d results, %0d of them clamped", checked, clamped);
		if (errors == 0 && pending == 0) begin
			$display("barometer_sample_compensation_test passed");
		end else begin
			$display("barometer_sample_compensation_test failed");
		end
		$finish;
	end

endmodule
